// ----- sv/ymf_pkg.sv -----
// Shared types, constants and the CRC step function of the YMODEM 1K block framer.
package ymf_pkg;

  // Framing geometry
  localparam int unsigned BLOCK_DATA_BYTES  = 1024;
  localparam int unsigned TRAILER_PAD_BYTES = 59;
  localparam int unsigned BLK_CNT_W         = $clog2(BLOCK_DATA_BYTES + 1);
  localparam int unsigned REP_W             = 10;

  // Byte codes
  localparam logic [7:0]  STX_BYTE  = 8'h02;
  localparam logic [7:0]  PAD_BYTE  = 8'h1A;
  localparam logic [7:0]  NULL_BYTE = 8'h00;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'h0000;
  localparam logic [7:0]  FRAME_FIRST = 8'h01;

  // Command handed from the front to the back through the queue
  typedef struct packed {
    logic [7:0]       data;
    logic [7:0]       frame;
    logic             hdr;
    logic             close;
    logic [REP_W-1:0] pad;
  } ymf_cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STX,
    ST_FRM,
    ST_FRM_N,
    ST_DATA,
    ST_PAD,
    ST_PAD_CRC,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_TRAIL
  } ymf_state_t;

  // One byte through CRC-16/XMODEM, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/ymodem_1k_block_framer_top.sv -----
// Top level of the YMODEM 1K block framer: front end, command queue and back end.
//
// Frames file bytes into YMODEM 1K blocks with a CRC-16/XMODEM check. Each input
// item yields one or more (byte, repeat) results; last_of_run marks the final
// result of an item and block_done the result that closes a block. In the
// back-end sequencer a byte in the middle of a block yields only its data result;
// the first byte of a block comes after start mark, frame number and complement.
// A byte that closes a block is followed by CRC high, CRC low and trailer results
// and, for a short block, before those by one result for the run of 0x1A pad
// bytes, after which the back end folds the padding into the CRC one byte per
// cycle. When the back end is idle, it first takes a command from the queue.
// The back-end sequencer loads at most one result per cycle into its output
// register while the output is not stalled; a two-entry queue lets the front
// end keep accepting bytes meanwhile.
module ymodem_1k_block_framer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [9:0] repeat_count,
  output logic       last_of_run,
  output logic       block_done
);

  logic              q_full;
  logic              push;
  ymf_pkg::ymf_cmd_t push_cmd;
  logic              pop;
  logic              head_valid;
  ymf_pkg::ymf_cmd_t head_cmd;

  ymf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  ymf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ymf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .last_of_run  (last_of_run),
    .block_done   (block_done)
  );

endmodule

// ----- sv/ymf_front.sv -----
// Front end: accepts file bytes, tracks block fill and frame number, builds commands.
module ymf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_file,
  input  logic               q_full,
  output logic               push,
  output ymf_pkg::ymf_cmd_t  push_cmd
);

  logic [ymf_pkg::BLK_CNT_W-1:0] blk_count;
  logic [ymf_pkg::BLK_CNT_W-1:0] blk_count_next;
  logic [7:0]                    frame_number;
  logic [7:0]                    frame_number_next;
  logic [ymf_pkg::BLK_CNT_W-1:0] cnt1;
  logic                          full_blk;
  logic                          close;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the item
  assign cnt1     = blk_count + ymf_pkg::BLK_CNT_W'(1);
  assign full_blk = cnt1 >= ymf_pkg::BLK_CNT_W'(ymf_pkg::BLOCK_DATA_BYTES);
  assign close    = full_blk || end_of_file;

  always_comb begin
    push_cmd.data  = data_byte;
    push_cmd.frame = frame_number;
    push_cmd.hdr   = (blk_count == '0);
    push_cmd.close = close;
    push_cmd.pad   = full_blk ? '0 :
                     ymf_pkg::REP_W'(ymf_pkg::BLK_CNT_W'(ymf_pkg::BLOCK_DATA_BYTES) - cnt1);
  end

  // Block counter and frame number
  always_comb begin
    blk_count_next    = blk_count;
    frame_number_next = frame_number;
    if (push) begin
      if (close) begin
        blk_count_next    = '0;
        frame_number_next = end_of_file ? ymf_pkg::FRAME_FIRST : frame_number + 8'd1;
      end else begin
        blk_count_next = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_count    <= '0;
      frame_number <= ymf_pkg::FRAME_FIRST;
    end else begin
      blk_count    <= blk_count_next;
      frame_number <= frame_number_next;
    end
  end

endmodule

// ----- sv/ymf_queue.sv -----
// Two-entry command queue between the front and back ends.
module ymf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ymf_pkg::ymf_cmd_t  push_cmd,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output ymf_pkg::ymf_cmd_t  head_cmd
);

  ymf_pkg::ymf_cmd_t slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = slot[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/ymf_back.sv -----
// Back end: sequences header, data, padding, CRC and trailer results into the output register.
module ymf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ymf_pkg::ymf_cmd_t  head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [9:0]         repeat_count,
  output logic               last_of_run,
  output logic               block_done
);

  localparam bit NO_TRAILER = (ymf_pkg::TRAILER_PAD_BYTES == 0);

  ymf_pkg::ymf_state_t            state;
  ymf_pkg::ymf_state_t            state_next;
  ymf_pkg::ymf_cmd_t              cmd;
  logic [15:0]                    crc;
  logic [ymf_pkg::REP_W-1:0]      pad_left;

  logic                           out_ready;
  logic                           emit;
  logic                           fin;
  logic [7:0]                     e_byte;
  logic [ymf_pkg::REP_W-1:0]      e_rep;
  logic                           e_last;
  logic                           e_done;
  ymf_pkg::ymf_state_t            first_state;

  assign out_ready   = !out_valid || !out_stall;
  assign first_state = head_cmd.hdr ? ymf_pkg::ST_STX : ymf_pkg::ST_DATA;
  assign pop         = head_valid &&
                       ((state == ymf_pkg::ST_IDLE) || (fin && out_ready));

  // Result selection per state
  always_comb begin
    emit   = 1'b0;
    fin    = 1'b0;
    e_byte = ymf_pkg::NULL_BYTE;
    e_rep  = ymf_pkg::REP_W'(1);
    e_last = 1'b0;
    e_done = 1'b0;
    unique case (state)
      ymf_pkg::ST_IDLE: begin
      end
      ymf_pkg::ST_STX: begin
        emit   = 1'b1;
        e_byte = ymf_pkg::STX_BYTE;
      end
      ymf_pkg::ST_FRM: begin
        emit   = 1'b1;
        e_byte = cmd.frame;
      end
      ymf_pkg::ST_FRM_N: begin
        emit   = 1'b1;
        e_byte = ~cmd.frame;
      end
      ymf_pkg::ST_DATA: begin
        emit   = 1'b1;
        e_byte = cmd.data;
        e_last = !cmd.close;
        fin    = !cmd.close;
      end
      ymf_pkg::ST_PAD: begin
        emit   = 1'b1;
        e_byte = ymf_pkg::PAD_BYTE;
        e_rep  = cmd.pad;
      end
      ymf_pkg::ST_PAD_CRC: begin
      end
      ymf_pkg::ST_CRC_HI: begin
        emit   = 1'b1;
        e_byte = crc[15:8];
      end
      ymf_pkg::ST_CRC_LO: begin
        emit   = 1'b1;
        e_byte = crc[7:0];
        e_last = NO_TRAILER;
        e_done = NO_TRAILER;
        fin    = NO_TRAILER;
      end
      ymf_pkg::ST_TRAIL: begin
        emit   = 1'b1;
        e_byte = ymf_pkg::NULL_BYTE;
        e_rep  = ymf_pkg::REP_W'(ymf_pkg::TRAILER_PAD_BYTES);
        e_last = 1'b1;
        e_done = 1'b1;
        fin    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ymf_pkg::ST_IDLE: begin
        if (head_valid) begin
          state_next = first_state;
        end
      end
      ymf_pkg::ST_PAD_CRC: begin
        if (pad_left == ymf_pkg::REP_W'(1)) begin
          state_next = ymf_pkg::ST_CRC_HI;
        end
      end
      default: begin
        if (out_ready) begin
          if (fin) begin
            state_next = head_valid ? first_state : ymf_pkg::ST_IDLE;
          end else begin
            unique case (state)
              ymf_pkg::ST_STX:    state_next = ymf_pkg::ST_FRM;
              ymf_pkg::ST_FRM:    state_next = ymf_pkg::ST_FRM_N;
              ymf_pkg::ST_FRM_N:  state_next = ymf_pkg::ST_DATA;
              ymf_pkg::ST_DATA:   state_next = (cmd.pad != '0) ? ymf_pkg::ST_PAD
                                                               : ymf_pkg::ST_CRC_HI;
              ymf_pkg::ST_PAD:    state_next = ymf_pkg::ST_PAD_CRC;
              ymf_pkg::ST_CRC_HI: state_next = ymf_pkg::ST_CRC_LO;
              ymf_pkg::ST_CRC_LO: state_next = ymf_pkg::ST_TRAIL;
              default:            state_next = ymf_pkg::ST_IDLE;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ymf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Current command
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
  end

  // Running CRC and pad counter
  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= ymf_pkg::CRC_INIT;
      pad_left <= '0;
    end else begin
      if (state == ymf_pkg::ST_DATA && out_ready) begin
        crc <= ymf_pkg::crc_feed(crc, cmd.data);
      end else if (state == ymf_pkg::ST_PAD && out_ready) begin
        pad_left <= cmd.pad;
      end else if (state == ymf_pkg::ST_PAD_CRC) begin
        crc      <= ymf_pkg::crc_feed(crc, ymf_pkg::PAD_BYTE);
        pad_left <= pad_left - ymf_pkg::REP_W'(1);
      end else if (e_done && out_ready) begin
        crc <= ymf_pkg::CRC_INIT;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_ready) begin
      out_byte     <= e_byte;
      repeat_count <= e_rep;
      last_of_run  <= e_last;
      block_done   <= e_done;
    end
  end

endmodule

// ----- bench/ymf_frame_checker.sv -----
// Checker for the YMODEM 1K block framer: predicts the framed stream and compares it.
`timescale 1ns / 100ps

module ymf_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [9:0] repeat_count,
  input  logic       last_of_run,
  input  logic       block_done,
  output int         mismatches,
  output int         results_due,
  output int         blocks_closed
);

  // One framed (byte, repeat) item as it should leave the block
  typedef struct packed {
    logic [7:0] val;
    logic [9:0] reps;
    logic       last;
    logic       done;
  } tx_byte_t;

  tx_byte_t    tx_due[$];
  logic [15:0] blk_crc  = ymf_pkg::CRC_INIT;
  logic [7:0]  frame_no = ymf_pkg::FRAME_FIRST;
  logic [10:0] blk_fill = '0;
  int          n_mis    = 0;
  int          n_blocks = 0;
  int          n_seen   = 0;

  // CRC-16/XMODEM, one byte, bit by bit from the MSB
  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ ymf_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] v, input logic [9:0] n, input logic d);
    tx_due.push_back('{val: v, reps: n, last: 1'b0, done: d});
  endtask

  // Expected framed output for one accepted file byte
  task automatic frame_file_byte(input logic [7:0] b, input logic eof);
    int unsigned fill;
    int unsigned pad;
    logic [7:0]  frame_inv;
    tx_byte_t    tail;
    // block header ahead of the first data byte
    if (blk_fill == 0) begin
      frame_inv = ~frame_no;
      push_byte(ymf_pkg::STX_BYTE, 10'd1, 1'b0);
      push_byte(frame_no, 10'd1, 1'b0);
      push_byte(frame_inv, 10'd1, 1'b0);
    end
    push_byte(b, 10'd1, 1'b0);
    blk_crc = crc_xmodem_step(blk_crc, b);
    fill    = blk_fill + 1;
    // block close: pad run, CRC high/low, null trailer
    if (fill >= ymf_pkg::BLOCK_DATA_BYTES || eof) begin
      if (fill < ymf_pkg::BLOCK_DATA_BYTES) begin
        pad = ymf_pkg::BLOCK_DATA_BYTES - fill;
        push_byte(ymf_pkg::PAD_BYTE, pad[9:0], 1'b0);
        repeat (pad) blk_crc = crc_xmodem_step(blk_crc, ymf_pkg::PAD_BYTE);
      end
      push_byte(blk_crc[15:8], 10'd1, 1'b0);
      push_byte(blk_crc[7:0], 10'd1, ymf_pkg::TRAILER_PAD_BYTES == 0);
      if (ymf_pkg::TRAILER_PAD_BYTES > 0) begin
        push_byte(ymf_pkg::NULL_BYTE, 10'(ymf_pkg::TRAILER_PAD_BYTES), 1'b1);
      end
      blk_crc  = ymf_pkg::CRC_INIT;
      fill     = 0;
      frame_no = eof ? ymf_pkg::FRAME_FIRST : frame_no + 8'd1;
      n_blocks++;
    end
    blk_fill = fill[10:0];
    // the final result of the item carries last_of_run
    tail      = tx_due.pop_back();
    tail.last = 1'b1;
    tx_due.push_back(tail);
  endtask

  task automatic report_mismatch(input string what);
    n_mis++;
    $display("%0t ns: result %0d: %s", $time, n_seen, what);
  endtask

  // Predict on accepted inputs, compare on accepted outputs
  always @(posedge clk) begin
    tx_byte_t want;
    if (rst) begin
      tx_due.delete();
      blk_crc  = ymf_pkg::CRC_INIT;
      frame_no = ymf_pkg::FRAME_FIRST;
      blk_fill = '0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_file_byte(data_byte, end_of_file);
      end
      if (out_valid && !out_stall) begin
        if (tx_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte 0x%02h", out_byte));
        end else begin
          want = tx_due.pop_front();
          if (out_byte !== want.val)
            report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", out_byte, want.val));
          if (repeat_count !== want.reps)
            report_mismatch($sformatf("repeat_count %0d, want %0d", repeat_count, want.reps));
          if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run, want.last));
          if (block_done !== want.done)
            report_mismatch($sformatf("block_done %b, want %b", block_done, want.done));
        end
        n_seen++;
      end
    end
    results_due   <= tx_due.size();
    mismatches    <= n_mis;
    blocks_closed <= n_blocks;
  end

endmodule

// ----- bench/ymodem_1k_block_framer_top_tb.sv -----
// Testbench top for the YMODEM 1K block framer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module ymodem_1k_block_framer_top_tb;

  localparam int CLK_HALF     = 10;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int RANDOM_BYTES = 405;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       end_of_file = 1'b0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [9:0] repeat_count;
  logic       last_of_run;
  logic       block_done;

  int mismatches;
  int results_due;
  int blocks_closed;
  int cycles     = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int stall_pct  = 0;
  int gap_pct    = 0;
  int stall_left = 0;

  always #(CLK_HALF) clk = ~clk;

  ymodem_1k_block_framer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_file  (end_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .last_of_run  (last_of_run),
    .block_done   (block_done)
  );

  ymf_frame_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_file   (end_of_file),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .repeat_count  (repeat_count),
    .last_of_run   (last_of_run),
    .block_done    (block_done),
    .mismatches    (mismatches),
    .results_due   (results_due),
    .blocks_closed (blocks_closed)
  );

  // Idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // File content with extra weight on the framing codes and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return ymf_pkg::PAD_BYTE;
      3:       return ymf_pkg::STX_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stalls in runs
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One file byte, with an optional gap ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int g;
    g = ($urandom_range(99) < gap_pct) ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_file(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1);
    end
    files_sent++;
  endtask

  // Hold the sender until the framed stream has fully drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  initial begin
    int len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: one-byte file (longest pad run), short files with extreme bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    files_sent += 2;
    wait_drained();
    stall_pct = 40;
    gap_pct   = 40;
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(ymf_pkg::PAD_BYTE, 1'b0);
    send_byte(ymf_pkg::STX_BYTE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'hFF, 1'b1);
    files_sent += 2;

    // Random files, mostly short, with changing idle pressure
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(3))
        0: begin stall_pct = 0;  gap_pct = 0;  end
        1: begin stall_pct = 5;  gap_pct = 10; end
        2: begin stall_pct = 25; gap_pct = 30; end
        3: begin stall_pct = 60; gap_pct = 60; end
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
        6, 7, 8:          len = $urandom_range(9, 60);
        default:          len = $urandom_range(61, 200);
      endcase
      if (len > RANDOM_BYTES - bytes_sent) len = RANDOM_BYTES - bytes_sent;
      send_file(len);
      if ($urandom_range(7) == 0) wait_drained();
    end

    // a new file after the random ones restarts at frame 1
    stall_pct = 30;
    gap_pct   = 30;
    send_file(5);

    wait_drained();
    repeat (64) @(posedge clk);

    $display("Covered %0d file bytes in %0d files, %0d blocks closed,", bytes_sent,
             files_sent, blocks_closed);
    $display("short final blocks with pad runs of many lengths, under random gaps and stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ymf_pkg.sv
sv/ymf_front.sv
sv/ymf_queue.sv
sv/ymf_back.sv
sv/ymodem_1k_block_framer_top.sv
bench/ymf_frame_checker.sv
bench/ymodem_1k_block_framer_top_tb.sv
